// ----- hw/rtl/adsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, widths and constants of the ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // fixed point: ONE = 1 << FRAC_BITS
  localparam int FRAC_BITS = 20;
  localparam int LVL_W     = FRAC_BITS + 1;        // level, 0 .. 2*ONE-1
  localparam int COEFF_W   = FRAC_BITS + 1;        // Q1.FRAC coefficient
  localparam int ATGT_W    = FRAC_BITS + 4;        // attack target, Q4.FRAC
  localparam int TGT_W     = ATGT_W + 1;           // signed target
  localparam int DIFF_W    = TGT_W + 1;            // target - level
  localparam int PROD_W    = DIFF_W + COEFF_W + 1; // signed product
  localparam int NV_W      = PROD_W - FRAC_BITS + 1;
  localparam int CFG_W     = ATGT_W;               // widest register

  localparam int LVL_ONE       = 1 << FRAC_BITS;
  localparam int LVL_MAX       = 2 * LVL_ONE - 1;
  localparam int REL_TARGET    = -((LVL_ONE + 50) / 100);
  localparam int DECAY_EPS     = (LVL_ONE + 5000) / 10000;
  localparam int ATGT_RESET    = (LVL_ONE * 101 + 50) / 100;
  localparam int SUSTAIN_RESET = (LVL_ONE * 7 + 5) / 10;

  typedef enum logic [2:0] {
    SEG_IDLE    = 3'd0,
    SEG_ATTACK  = 3'd1,
    SEG_DECAY   = 3'd2,
    SEG_SUSTAIN = 3'd3,
    SEG_RELEASE = 3'd4
  } seg_e;

  typedef enum logic [2:0] {
    CFG_ATTACK_COEFF  = 3'd0,
    CFG_DECAY_COEFF   = 3'd1,
    CFG_RELEASE_COEFF = 3'd2,
    CFG_ATTACK_TARGET = 3'd3,
    CFG_SUSTAIN_LEVEL = 3'd4
  } cfg_idx_e;

endpackage

// ----- hw/rtl/adsr_envelope_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// ADSR envelope with one-pole exponential segments, Q1.20 fixed point level.
// ----------------------------------------------------------------------------
// Each item is one sample tick and gives exactly one result item (level and
// segment). The block takes one item per clock cycle while the result is not
// stalled; a result passes through the input register, then the result
// register, before it can be taken.
// The per-cycle path is one 26x22 signed multiply and an add in the pole step
// unit, followed by the clamp and segment compares. Coefficient
// computation (exp/log) is done by software and written through the
// configuration port, which must only be written while the block is idle.
// ----------------------------------------------------------------------------
module adsr_envelope_generator
  import adsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               gate_i,
  input  logic               retrigger_i,
  input  logic               hard_restart_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LVL_W-1:0]   level_o,
  output logic [2:0]         segment_o
);

  localparam logic signed [NV_W-1:0]  NvOne   = NV_W'(LVL_ONE);
  localparam logic signed [NV_W-1:0]  NvMax   = NV_W'(LVL_MAX);
  localparam logic signed [LVL_W:0]   DecEps  = (LVL_W+1)'(DECAY_EPS);
  localparam logic signed [TGT_W-1:0] RelTgt  = TGT_W'(REL_TARGET);

  // configuration registers
  logic [COEFF_W-1:0] atk_coeff_q, dec_coeff_q, rel_coeff_q;
  logic [ATGT_W-1:0]  atk_tgt_q;
  logic [LVL_W-1:0]   sus_q;

  // input stage
  logic in_vld_q;
  logic gate_q, retrig_q, hard_q;

  // envelope state
  logic [LVL_W-1:0] lvl_q, lvl_d;
  seg_e             seg_q, seg_d;
  logic             pgate_q;

  // result stage
  logic             out_vld_q;
  logic [LVL_W-1:0] res_lvl_q, res_lvl_d;
  seg_e             res_seg_q;

  logic advance;

  // step operands and result
  seg_e                      seg_cur;
  logic [LVL_W-1:0]          lvl_cur;
  logic signed [TGT_W-1:0]   tgt;
  logic [COEFF_W-1:0]        coeff;
  logic signed [NV_W-1:0]    nv;
  logic [LVL_W-1:0]          nv_sat;
  logic signed [LVL_W:0]     dec_diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_coeff_q <= COEFF_W'(LVL_ONE);
      dec_coeff_q <= COEFF_W'(LVL_ONE);
      rel_coeff_q <= COEFF_W'(LVL_ONE);
      atk_tgt_q   <= ATGT_W'(ATGT_RESET);
      sus_q       <= LVL_W'(SUSTAIN_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ATTACK_COEFF:  atk_coeff_q <= cfg_data_i[COEFF_W-1:0];
        CFG_DECAY_COEFF:   dec_coeff_q <= cfg_data_i[COEFF_W-1:0];
        CFG_RELEASE_COEFF: rel_coeff_q <= cfg_data_i[COEFF_W-1:0];
        CFG_ATTACK_TARGET: atk_tgt_q   <= cfg_data_i[ATGT_W-1:0];
        CFG_SUSTAIN_LEVEL: sus_q       <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // the input stage moves on whenever the result register is free
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      gate_q   <= gate_i;
      retrig_q <= retrigger_i;
      hard_q   <= hard_restart_i;
    end
  end

  adsr_pole_step u_step (
    .lvl_i   (lvl_cur),
    .tgt_i   (tgt),
    .coeff_i (coeff),
    .nv_o    (nv)
  );

  always_comb begin
    // retrigger first, then gate edges
    seg_cur = retrig_q ? SEG_ATTACK : seg_q;
    if (gate_q && !pgate_q) begin
      seg_cur = SEG_ATTACK;
    end else if (!gate_q && pgate_q) begin
      seg_cur = SEG_RELEASE;
    end
    lvl_cur = (retrig_q && hard_q) ? '0 : lvl_q;

    case (seg_cur)
      SEG_ATTACK: begin
        tgt   = $signed({1'b0, atk_tgt_q});
        coeff = atk_coeff_q;
      end
      SEG_DECAY: begin
        tgt   = $signed({{(TGT_W-LVL_W){1'b0}}, sus_q});
        coeff = dec_coeff_q;
      end
      default: begin
        tgt   = RelTgt;
        coeff = rel_coeff_q;
      end
    endcase

    // clamp to 0 .. LEVEL_MAX
    if (nv[NV_W-1]) begin
      nv_sat = '0;
    end else if (nv > NvMax) begin
      nv_sat = LVL_W'(LVL_MAX);
    end else begin
      nv_sat = nv[LVL_W-1:0];
    end
    dec_diff = $signed({1'b0, nv_sat}) - $signed({1'b0, sus_q});

    lvl_d     = lvl_cur;
    seg_d     = seg_cur;
    res_lvl_d = '0;
    case (seg_cur)
      SEG_ATTACK: begin
        if (nv > NvOne) begin
          lvl_d = LVL_W'(LVL_ONE);
          seg_d = SEG_DECAY;
        end else begin
          lvl_d = nv_sat;
        end
        res_lvl_d = lvl_d;
      end
      SEG_DECAY: begin
        lvl_d     = nv_sat;
        res_lvl_d = nv_sat;
        if (dec_diff < DecEps && dec_diff > -DecEps) begin
          seg_d = SEG_SUSTAIN;
        end
      end
      SEG_SUSTAIN: begin
        res_lvl_d = sus_q;
      end
      SEG_RELEASE: begin
        lvl_d     = nv_sat;
        res_lvl_d = nv_sat;
        if (nv[NV_W-1]) begin
          seg_d = SEG_IDLE;
        end
      end
      default: begin
        seg_d = SEG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q   <= '0;
      seg_q   <= SEG_IDLE;
      pgate_q <= 1'b0;
    end else if (advance) begin
      lvl_q   <= lvl_d;
      seg_q   <= seg_d;
      pgate_q <= gate_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_lvl_q <= res_lvl_d;
      res_seg_q <= seg_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign level_o     = res_lvl_q;
  assign segment_o   = res_seg_q;

endmodule

// ----- hw/rtl/adsr_pole_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pole_step
// One-pole step: level + floor(coeff * (target - level) / ONE).
// ----------------------------------------------------------------------------
module adsr_pole_step
  import adsr_pkg::*;
(
  input  logic        [LVL_W-1:0]   lvl_i,
  input  logic signed [TGT_W-1:0]   tgt_i,
  input  logic        [COEFF_W-1:0] coeff_i,
  output logic signed [NV_W-1:0]    nv_o
);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-FRAC_BITS-1:0] step;

  assign diff = $signed({{(DIFF_W-TGT_W){tgt_i[TGT_W-1]}}, tgt_i})
              - $signed({{(DIFF_W-LVL_W){1'b0}}, lvl_i});
  assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, coeff_i}));
  // dropping the fraction bits of a two's complement product is a floor
  assign step = prod[PROD_W-1:FRAC_BITS];
  assign nv_o = $signed({step[PROD_W-FRAC_BITS-1], step})
              + $signed({{(NV_W-LVL_W){1'b0}}, lvl_i});

endmodule
